// ===== src/bfsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsa_pkg: shared types and constants
// Free-list entry, cell and list commands, state encoding, status codes.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int FREE_ENTRIES = 16;
  localparam int GRANULE      = 128;
  localparam int PAGE_BYTES   = 4096;
  localparam int HDR          = 16;

  localparam int POS_W  = $clog2(FREE_ENTRIES);
  localparam int CNT_W  = $clog2(FREE_ENTRIES + 1);
  localparam int GRAN_W = $clog2(GRANULE);
  localparam int PAGE_W = $clog2(PAGE_BYTES);

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 40;
  localparam int LEN_W  = 32;
  localparam int NB_W   = 33;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR,
    CELL_LOAD
  } cell_op_t;

  typedef enum logic [1:0] {
    LIST_NONE,
    LIST_REMOVE,
    LIST_INSERT,
    LIST_CLEAR
  } list_op_t;

  typedef struct packed {
    list_op_t         op;
    logic [POS_W-1:0] pos;
    entry_t           ent;
  } list_cmd_t;

  typedef struct packed {
    logic             hit;      // some valid entry is bad or fits
    logic             hit_bad;  // first such entry has a bad size
    logic [POS_W-1:0] hit_pos;
    entry_t           hit_ent;
    logic [CNT_W-1:0] ins_pos;  // sorted insert slot for the key
    logic             full;
  } list_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_INS,
    S_DONE
  } state_t;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOMEM    = 3'd1;
  localparam logic [2:0] ST_BADSIZE  = 3'd2;
  localparam logic [2:0] ST_BADARENA = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

endpackage

// ===== src/bfsa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsa_cell: one free-list slot
// Holds one entry, shifts to/from neighbors, compares its size to the key.
// ----------------------------------------------------------------------------
module bfsa_cell
  import bfsa_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  entry_t            from_left,
  input  entry_t            from_right,
  input  entry_t            load_ent,
  input  logic [SIZE_W-1:0] key,
  output entry_t            ent,
  output logic              ge,
  output logic              bad
);

  entry_t ent_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_SHL:  ent_r <= from_right;
      CELL_SHR:  ent_r <= from_left;
      CELL_LOAD: ent_r <= load_ent;
      default:   ent_r <= ent_r;
    endcase
  end

  assign ent = ent_r;
  assign ge  = (ent_r.size >= key);
  // legal chunk sizes are nonzero, below 2^32 and 16-byte multiples
  assign bad = (ent_r.size == '0) || (ent_r.size[SIZE_W-1:32] != '0) ||
               (ent_r.size[3:0] != '0);

endmodule

// ===== src/bfsa_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfsa_list: size-sorted free list
// Chain of cells plus fill count; first-fit search and shift control.
// ----------------------------------------------------------------------------
module bfsa_list
  import bfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  list_cmd_t         cmd,
  input  logic [SIZE_W-1:0] key,
  output list_stat_t        stat
);

  logic [CNT_W-1:0] count_r, count_nxt;
  cell_op_t         ops  [FREE_ENTRIES];
  entry_t           ents [FREE_ENTRIES];
  logic [FREE_ENTRIES-1:0] ge_v, bad_v;

  for (genvar k = 0; k < FREE_ENTRIES; k++) begin : g_cell
    entry_t lft, rgt;
    if (k == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid
      assign lft = ents[k-1];
    end
    if (k == FREE_ENTRIES - 1) begin : g_last
      assign rgt = ents[k];
    end else begin : g_inner
      assign rgt = ents[k+1];
    end
    bfsa_cell u_cell (
      .clk        (clk),
      .op         (ops[k]),
      .from_left  (lft),
      .from_right (rgt),
      .load_ent   (cmd.ent),
      .key        (key),
      .ent        (ents[k]),
      .ge         (ge_v[k]),
      .bad        (bad_v[k])
    );
  end

  always_comb begin
    for (int k = 0; k < FREE_ENTRIES; k++) begin
      ops[k] = CELL_HOLD;
      unique case (cmd.op)
        LIST_REMOVE: if (POS_W'(k) >= cmd.pos) ops[k] = CELL_SHL;
        LIST_INSERT: begin
          if (POS_W'(k) == cmd.pos) ops[k] = CELL_LOAD;
          else if (POS_W'(k) > cmd.pos) ops[k] = CELL_SHR;
        end
        default: ops[k] = CELL_HOLD;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.op)
      LIST_REMOVE: count_nxt = count_r - CNT_W'(1);
      LIST_INSERT: count_nxt = count_r + CNT_W'(1);
      LIST_CLEAR:  count_nxt = '0;
      default:     count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  // priority search, lowest slot wins
  always_comb begin
    stat.hit     = 1'b0;
    stat.hit_bad = 1'b0;
    stat.hit_pos = '0;
    stat.ins_pos = count_r;
    for (int k = FREE_ENTRIES - 1; k >= 0; k--) begin
      if (CNT_W'(k) < count_r) begin
        if (ge_v[k] || bad_v[k]) begin
          stat.hit     = 1'b1;
          stat.hit_bad = bad_v[k];
          stat.hit_pos = POS_W'(k);
        end
        if (ge_v[k]) stat.ins_pos = CNT_W'(k);
      end
    end
    stat.hit_ent = ents[stat.hit_pos];
    stat.full    = (count_r >= CNT_W'(FREE_ENTRIES));
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FREE_ENTRIES))
    else $error("free count above capacity");
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == LIST_INSERT |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow list");
  a_rm_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == LIST_REMOVE |-> count_r != '0)
    else $error("remove on empty list");
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == LIST_INSERT |-> !stat.full)
    else $error("insert into full list");
`endif

endmodule

// ===== src/best_fit_sorted_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_sorted_free_list_allocator_top: best-fit heap allocator
// Size-sorted free list in a cell chain, bump pointer top, page alignment.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tuser opcode, tdata request fields
//  out_    | out | tvalid/tready      | tuser status, tdata address/size
//  cfg_    | in  | we (no wait)       | index 0 arena_base, 1 arena_length
//
//  One beat at a time: top-only work passes S_EXEC then S_DONE; a free-list
//  insert adds S_FIND (search) and S_INS (shift in the cell chain) between
//  them, and S_DONE waits while the result register is occupied and out_tready low.
//  A new beat is accepted while the previous result waits on out_.
//  Reset (rst_n low, synchronous): empty free list, top at 0 with 4096 bytes.
//  Stalls on out_ hold the result register and block completion only.
// ----------------------------------------------------------------------------
module best_fit_sorted_free_list_allocator_top
  import bfsa_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [119:0]  in_tdata,   // request_length, page_align, address, chunk_size
  input  logic [1:0]    in_tuser,   // opcode
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [87:0]   out_tdata,  // granted_address, granted_size
  output logic [2:0]    out_tuser,  // status
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [47:0]   cfg_wdata
);

  state_t state_r, state_nxt;

  // configuration
  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] len_r;

  // arena top
  logic [ADDR_W-1:0] top_ptr_r, top_ptr_nxt;
  logic [SIZE_W-1:0] top_rem_r, top_rem_nxt;

  // captured beat
  logic [1:0]        op_r;
  logic [LEN_W-1:0]  rlen_r;
  logic              align_r;
  logic [ADDR_W-1:0] mem_r;
  logic [NB_W-1:0]   csize_r;

  // pending insert and result
  entry_t            ins_r, ins_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [2:0]        rst_stat_r, rst_stat_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [NB_W-1:0]   res_size_r, res_size_nxt;

  // output register
  logic              out_valid_r;
  logic [2:0]        out_stat_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [NB_W-1:0]   out_size_r;

  list_cmd_t         cmd;
  list_stat_t        lst;
  logic [SIZE_W-1:0] key;

  // chunk size: (len + 16) rounded up to the granule
  logic [NB_W-1:0]   nb_sum, nb;
  logic [PAGE_W-1:0] gap;
  logic [SIZE_W-1:0] rem_gap;
  logic [ADDR_W-1:0] chunk, cfree;
  logic [SIZE_W:0]   merge_sum;
  logic [SIZE_W-1:0] split_rem;

  assign nb_sum = NB_W'(rlen_r) + NB_W'(HDR + GRANULE - 1);
  assign nb     = {nb_sum[NB_W-1:GRAN_W], GRAN_W'(0)};
  assign gap    = PAGE_W'(PAGE_BYTES - HDR) - top_ptr_r[PAGE_W-1:0];
  assign rem_gap   = top_rem_r - SIZE_W'(gap);
  assign chunk     = top_ptr_r + ADDR_W'(gap);
  assign cfree     = mem_r - ADDR_W'(HDR);
  assign merge_sum = (SIZE_W+1)'(top_rem_r) + (SIZE_W+1)'(csize_r);
  assign split_rem = lst.hit_ent.size - SIZE_W'(nb);

  assign key = (state_r == S_EXEC) ? SIZE_W'(nb) : ins_r.size;

  bfsa_list u_list (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .key  (key),
    .stat (lst)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    top_ptr_nxt  = top_ptr_r;
    top_rem_nxt  = top_rem_r;
    ins_nxt      = ins_r;
    rst_stat_nxt = rst_stat_r;
    res_addr_nxt = res_addr_r;
    res_size_nxt = res_size_r;
    cmd          = '{op: LIST_NONE, pos: pos_r, ent: ins_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        rst_stat_nxt = ST_OK;
        res_addr_nxt = '0;
        res_size_nxt = '0;
        state_nxt    = S_DONE;
        case (op_r)
          OP_ALLOC: begin
            if (!align_r) begin
              if (lst.hit) begin
                if (lst.hit_bad) begin
                  rst_stat_nxt = ST_BADSIZE;
                end else begin
                  // best fit: take it, split off any remainder
                  cmd.op       = LIST_REMOVE;
                  cmd.pos      = lst.hit_pos;
                  res_addr_nxt = lst.hit_ent.addr + ADDR_W'(HDR);
                  res_size_nxt = nb;
                  if (split_rem != '0) begin
                    ins_nxt.addr = lst.hit_ent.addr + ADDR_W'(nb);
                    ins_nxt.size = split_rem;
                    state_nxt    = S_FIND;
                  end
                end
              end else if (top_rem_r < SIZE_W'(nb)) begin
                rst_stat_nxt = ST_NOMEM;
              end else begin
                res_addr_nxt = top_ptr_r + ADDR_W'(HDR);
                res_size_nxt = nb;
                top_ptr_nxt  = top_ptr_r + ADDR_W'(nb);
                top_rem_nxt  = top_rem_r - SIZE_W'(nb);
              end
            end else begin
              // page-aligned: carve gap so the user address lands on a page
              if (top_rem_r < SIZE_W'(gap)) begin
                rst_stat_nxt = ST_NOMEM;
              end else if (gap != '0 && gap[3:0] != '0) begin
                rst_stat_nxt = ST_BADSIZE;
              end else if (rem_gap < SIZE_W'(nb)) begin
                rst_stat_nxt = ST_NOMEM;
              end else if (gap != '0 && lst.full) begin
                rst_stat_nxt = ST_FULL;
              end else begin
                res_addr_nxt = chunk + ADDR_W'(HDR);
                res_size_nxt = nb;
                top_ptr_nxt  = chunk + ADDR_W'(nb);
                top_rem_nxt  = rem_gap - SIZE_W'(nb);
                if (gap != '0) begin
                  ins_nxt.addr = top_ptr_r;
                  ins_nxt.size = SIZE_W'(gap);
                  state_nxt    = S_FIND;
                end
              end
            end
          end
          OP_FREE: begin
            if (mem_r == '0) begin
              rst_stat_nxt = ST_OK;
            end else if (csize_r == '0 || csize_r[NB_W-1] || csize_r[3:0] != '0) begin
              rst_stat_nxt = ST_BADSIZE;
            end else if (cfree + ADDR_W'(csize_r) == top_ptr_r) begin
              // adjacent to top: merge, saturating
              top_ptr_nxt = cfree;
              top_rem_nxt = merge_sum[SIZE_W] ? '1 : merge_sum[SIZE_W-1:0];
            end else if (lst.full) begin
              rst_stat_nxt = ST_FULL;
            end else begin
              ins_nxt.addr = cfree;
              ins_nxt.size = SIZE_W'(csize_r);
              state_nxt    = S_FIND;
            end
          end
          OP_INIT: begin
            if (len_r == '0 || len_r[PAGE_W-1:0] != '0) begin
              rst_stat_nxt = ST_BADARENA;
            end else begin
              top_ptr_nxt = base_r;
              top_rem_nxt = len_r;
              cmd.op      = LIST_CLEAR;
            end
          end
          default: rst_stat_nxt = ST_OK;
        endcase
      end
      S_FIND: state_nxt = S_INS;
      S_INS: begin
        cmd.op    = LIST_INSERT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      len_r       <= SIZE_W'(PAGE_BYTES);
      top_ptr_r   <= '0;
      top_rem_r   <= SIZE_W'(PAGE_BYTES);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      top_ptr_r <= top_ptr_nxt;
      top_rem_r <= top_rem_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE:   base_r <= cfg_wdata;
          REG_LENGTH: len_r  <= cfg_wdata[SIZE_W-1:0];
          default:    base_r <= base_r;
        endcase
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r    <= in_tuser;
      rlen_r  <= in_tdata[31:0];
      align_r <= in_tdata[32];
      mem_r   <= in_tdata[80:33];
      csize_r <= in_tdata[113:81];
    end
    ins_r      <= ins_nxt;
    rst_stat_r <= rst_stat_nxt;
    res_addr_r <= res_addr_nxt;
    res_size_r <= res_size_nxt;
    if (state_r == S_FIND) pos_r <= lst.ins_pos[POS_W-1:0];
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_stat_r <= rst_stat_r;
      out_addr_r <= res_addr_r;
      out_size_r <= res_size_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {7'b0, out_size_r, out_addr_r};

`ifndef SYNTHESIS
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("accept while busy");
  a_ins_after_find: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIND |=> state_r == S_INS)
    else $error("insert did not follow search");
  a_ok_nonzero_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[80:48] == '0)
    else $error("failed beat carries a size");
`endif

endmodule

// ===== tb/best_fit_sorted_free_list_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_sorted_free_list_allocator_top_tb: self-checking allocator bench
// Drives allocate/free/init beats over several arena settings, predicts every
// result with a behavioral allocator and compares status, address and size.
// ----------------------------------------------------------------------------
module best_fit_sorted_free_list_allocator_top_tb;
  import bfsa_pkg::*;

  localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned M40 = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] len;
    logic        align;
    logic [47:0] addr;
    logic [32:0] csize;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [47:0] addr;
    logic [32:0] size;
  } grant_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;   // request_length, page_align, address, chunk_size
  logic [1:0]   in_tuser;   // opcode
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;  // granted_address, granted_size
  logic [2:0]   out_tuser;  // status
  logic         cfg_we;
  logic         cfg_index;
  logic [47:0]  cfg_wdata;

  best_fit_sorted_free_list_allocator_top dut (.*);

  // Stimulus and checking state
  request_t request_q[$];
  grant_t   grant_q[$];
  grant_t   live_chunks[$];   // granted chunks not yet handed back
  int       errors = 0;
  bit       calm = 0;         // final stretch: no idling on either side

  // Shadow allocator state
  longint unsigned sh_base, sh_length, sh_top, sh_rem;
  longint unsigned sh_faddr[FREE_ENTRIES];
  longint unsigned sh_fsize[FREE_ENTRIES];
  int              sh_count;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Behavioral allocator
  // --------------------------------------------------------------------------
  function automatic bit size_bad(longint unsigned s);
    return s == 0 || s >= 64'h1_0000_0000 || (s & 64'hf) != 0;
  endfunction

  function automatic void list_put(longint unsigned a, longint unsigned s);
    int pos;
    pos = 0;
    while (pos < sh_count && sh_fsize[pos] < s) pos++;
    for (int k = sh_count; k > pos; k--) begin
      sh_faddr[k] = sh_faddr[k-1];
      sh_fsize[k] = sh_fsize[k-1];
    end
    sh_faddr[pos] = a & M48;
    sh_fsize[pos] = s & M40;
    sh_count++;
  endfunction

  function automatic void list_take(int pos);
    for (int k = pos; k + 1 < sh_count; k++) begin
      sh_faddr[k] = sh_faddr[k+1];
      sh_fsize[k] = sh_fsize[k+1];
    end
    sh_count--;
  endfunction

  function automatic logic [2:0] carve(longint unsigned len, bit align,
                                       output longint unsigned ga,
                                       output longint unsigned gs);
    longint unsigned nb, s, a, gap, chunk;
    nb = ((len + HDR + GRANULE - 1) / GRANULE) * GRANULE;
    ga = 0;
    gs = 0;
    if (!align) begin
      // sorted list: first fit is best fit
      for (int i = 0; i < sh_count; i++) begin
        s = sh_fsize[i];
        if (size_bad(s)) return ST_BADSIZE;
        if (s >= nb) begin
          a = sh_faddr[i];
          list_take(i);
          if (s != nb) list_put(a + nb, s - nb);
          ga = (a + HDR) & M48;
          gs = nb;
          return ST_OK;
        end
      end
      if (sh_rem < nb) return ST_NOMEM;
      ga = (sh_top + HDR) & M48;
      gs = nb;
      sh_top = (sh_top + nb) & M48;
      sh_rem -= nb;
      return ST_OK;
    end
    // page aligned: gap so that chunk+HDR lands on a page boundary
    gap = ((PAGE_BYTES - HDR) - (sh_top & (PAGE_BYTES - 1))) & (PAGE_BYTES - 1);
    if (sh_rem < gap) return ST_NOMEM;
    if (gap != 0 && size_bad(gap)) return ST_BADSIZE;
    if (sh_rem - gap < nb) return ST_NOMEM;
    if (gap != 0 && sh_count >= FREE_ENTRIES) return ST_FULL;
    a = sh_top;
    chunk = (sh_top + gap) & M48;
    sh_top = (chunk + nb) & M48;
    sh_rem -= gap + nb;
    if (gap != 0) list_put(a, gap);
    ga = (chunk + HDR) & M48;
    gs = nb;
    return ST_OK;
  endfunction

  function automatic logic [2:0] reclaim(longint unsigned mem, longint unsigned s);
    longint unsigned c;
    if (mem == 0) return ST_OK;
    if (size_bad(s)) return ST_BADSIZE;
    c = (mem - HDR) & M48;
    if (((c + s) & M48) == sh_top) begin
      sh_top = c;
      sh_rem += s;
      if (sh_rem > M40) sh_rem = M40;
      return ST_OK;
    end
    if (sh_count >= FREE_ENTRIES) return ST_FULL;
    list_put(c, s);
    return ST_OK;
  endfunction

  function automatic grant_t grant_predict(request_t r);
    grant_t g;
    longint unsigned ga, gs;
    g = '{status: ST_OK, addr: '0, size: '0};
    if (r.op == OP_ALLOC) begin
      g.status = carve(r.len, r.align, ga, gs);
      if (g.status == ST_OK) begin
        g.addr = ga[47:0];
        g.size = gs[32:0];
        live_chunks.push_back(g);
      end
    end else if (r.op == OP_FREE) begin
      g.status = reclaim(r.addr, r.csize);
    end else if (r.op == OP_INIT) begin
      if (sh_length == 0 || (sh_length & (PAGE_BYTES - 1)) != 0) begin
        g.status = ST_BADARENA;
      end else begin
        sh_top = sh_base;
        sh_rem = sh_length;
        sh_count = 0;
        live_chunks.delete();
      end
    end
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: inserts random idle gaps, predicts on each accepted beat
  // --------------------------------------------------------------------------
  int       send_gap;
  request_t nxt;
  request_t seen;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        seen.op    = in_tuser;
        seen.len   = in_tdata[31:0];
        seen.align = in_tdata[32];
        seen.addr  = in_tdata[80:33];
        seen.csize = in_tdata[113:81];
        grant_q.push_back(grant_predict(seen));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (request_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap  <= $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else begin
          nxt = request_q.pop_front();
          in_tuser  <= nxt.op;
          in_tdata  <= {6'd0, nxt.csize, nxt.addr, nxt.align, nxt.len};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off to back the block up
  // --------------------------------------------------------------------------
  int cyc;
  int stall;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      cyc        <= 0;
      stall      <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc >= 3000 && cyc < 3400) begin
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (stall > 0) begin
        stall      <= stall - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall      <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  grant_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (grant_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: st=%0d addr=%h size=%h",
                   out_tuser, out_tdata[47:0], out_tdata[80:48]);
      end else begin
        want = grant_q.pop_front();
        if (out_tuser !== want.status || out_tdata[47:0] !== want.addr ||
            out_tdata[80:48] !== want.size) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d addr=%h size=%h  got st=%0d addr=%h size=%h",
                     want.status, want.addr, want.size,
                     out_tuser, out_tdata[47:0], out_tdata[80:48]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_req(logic [1:0] op, logic [31:0] len, logic al,
                          logic [47:0] a, logic [32:0] cs);
    request_t r;
    r = '{op: op, len: len, align: al, addr: a, csize: cs};
    request_q.push_back(r);
  endtask

  // sender pause: everything sent, everything back, block settled
  task automatic settle();
    while (request_q.size() != 0 || in_tvalid || grant_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_tvalid) @(posedge clk);
  endtask

  task automatic set_arena(logic [47:0] b, logic [39:0] l);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_index <= REG_LENGTH;
    cfg_wdata <= {8'($urandom), l};   // upper bits are ignored
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_base   = b;
    sh_length = l;
    push_req(OP_INIT, '0, 1'b0, '0, '0);
  endtask

  task automatic random_items(int n);
    int      pick, k;
    grant_t  c;
    for (int i = 0; i < n; i += 8) begin
      for (int j = 0; j < 8; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
          push_req(OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20000)
                             : $urandom_range(0, 600), 1'b0, 48'($urandom), 33'($urandom));
        end else if (pick < 52) begin
          push_req(OP_ALLOC, $urandom_range(0, 3000), 1'b1, '0, '0);
        end else if (pick < 88 && live_chunks.size() > 0) begin
          k = $urandom_range(0, live_chunks.size() - 1);
          c = live_chunks[k];
          live_chunks.delete(k);
          push_req(OP_FREE, 32'($urandom), 1'($urandom), c.addr, c.size);
        end else if (pick < 98) begin
          // noise: any opcode, any field values
          push_req(2'($urandom), $urandom, 1'($urandom),
                   {16'($urandom), 32'($urandom)}, {1'($urandom), 32'($urandom)});
        end else begin
          push_req(OP_INIT, '0, 1'b0, '0, '0);
        end
      end
      drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_BASE;
    cfg_wdata = '0;
    sh_base = 0; sh_length = 4096; sh_top = 0; sh_rem = 4096; sh_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset arena, extremes of fields, every opcode and special case
    push_req(OP_ALLOC, 32'd0, 1'b0, '0, '0);
    push_req(OP_ALLOC, 32'd112, 1'b0, '0, '0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 1'b0, '0, '0);    // out of memory
    push_req(OP_ALLOC, 32'd100, 1'b1, '0, '0);          // aligned, out of memory after the gap
    push_req(OP_FREE, 32'd0, 1'b0, 48'd0, 33'd128);     // free of null
    push_req(OP_FREE, '0, 1'b0, 48'h10, 33'd0);         // bad sizes
    push_req(OP_FREE, '0, 1'b0, 48'h10, 33'd8);
    push_req(OP_FREE, '0, 1'b0, 48'h10, 33'h1_0000_0000);
    push_req(OP_FREE, '0, 1'b0, 48'h10, 33'd128);       // back into free list
    push_req(OP_ALLOC, 32'd50, 1'b0, '0, '0);           // best fit from list
    push_req(2'd3, '1, 1'b1, '1, '1);                   // unused opcode
    push_req(OP_INIT, '0, 1'b0, '0, '0);
    drain();
    set_arena(48'h0, 40'h0);                            // bad lengths
    set_arena(48'h0, 40'h1800);

    set_arena(48'h1_0000, 40'h1_0000);
    random_items(320);
    set_arena(48'hFFFF_FFFF_F000, 40'hFF_FFFF_F000);    // wraps, max length
    random_items(240);
    drain();
    settle();
    // merge into top with the saturating add
    push_req(OP_FREE, '0, 1'b0, 48'((sh_top - 64'hFFFF_FFF0 + HDR) & M48), 33'hFFFF_FFF0);
    push_req(OP_ALLOC, 32'd4000, 1'b1, '0, '0);
    random_items(80);
    set_arena(48'h2345_0008, 40'h4_0000);               // unaligned base
    random_items(240);
    set_arena(48'h8000_0000, 40'h8000);                 // tight arena: no memory
    random_items(320);
    set_arena(48'h4_0000_0000, 40'h10_0000);
    random_items(480);
    settle();
    calm = 1;
    random_items(240);

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
